FILE: sv/ps2_mouse_packet_cursor_tracker_top_defines.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_TOP_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising edge, disabled while reset is asserted.
`define PMT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define PMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PMT_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define PMT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/ps2_mct_pkg.sv
package ps2_mct_pkg;

    // Width of the tracked cursor position.
    localparam int POS_WIDTH = 12;
    // Width of the clamp registers and of the reported cursor fields.
    localparam int CFG_W     = 12;
    localparam int COORD_W   = 12;
    // Arithmetic width: wide enough for a position plus a 256 delta.
    localparam int CALC_W    = ((POS_WIDTH > CFG_W) ? POS_WIDTH : CFG_W) + 1;

    localparam int BYTE_W    = 8;
    localparam int MAG_W     = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 1;

    typedef logic [POS_WIDTH-1:0] t_pos;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [COORD_W-1:0]   t_coord;
    typedef logic [CALC_W-1:0]    t_calc;
    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [MAG_W-1:0]     t_mag;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_MAX_X = 1'd0;
    localparam t_cfg_idx REG_MAX_Y = 1'd1;

    localparam t_cfg MAX_X_RESET = t_cfg'(640);
    localparam t_cfg MAX_Y_RESET = t_cfg'(480);

    localparam t_pos POS_TOP   = {POS_WIDTH{1'b1}};
    localparam t_mag SIGN_SPAN = t_mag'(9'h100);

    // Header bit positions of the standard three-byte packet.
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;

    // Magnitude of a 9-bit delta built from a data byte and its sign bit.
    function automatic t_mag delta_mag(input t_byte b, input logic neg);
        t_mag m;
        m = neg ? (SIGN_SPAN - t_mag'(b)) : t_mag'(b);
        return m;
    endfunction

endpackage

FILE: sv/ps2_mouse_packet_cursor_tracker_top.sv
// A registered result reaches the master side the cycle after the third byte is accepted.
// One byte per cycle while the input side is free; the header and X bytes give no result.
// The output register frees the input side whenever it is empty or being drained.
// Reset (i_rst_n low, synchronous): packet phase, header, positions and buttons clear,
// clamps return to 640 by 480, and no result is pending.
`include "ps2_mouse_packet_cursor_tracker_top_defines.svh"

module ps2_mouse_packet_cursor_tracker_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  ps2_mct_pkg::t_cfg_idx                i_cfg_idx,
    input  ps2_mct_pkg::t_cfg                    i_cfg_data,
    // Byte stream from the mouse.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ps2_mct_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
    // Decoded packet stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [24] left_down, [25] middle_down,
    // [26] right_down, [31:27] zero
    output logic [ps2_mct_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] click_event, [1] click_kind
    output logic [ps2_mct_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import ps2_mct_pkg::*;

    // Where the next byte lands in the packet. The fourth code is never
    // entered; if it were, it would be handled like the header phase.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } t_phase;

    t_phase r_phase, n_phase;
    t_byte  r_header, n_header;
    t_byte  r_dx, n_dx;
    t_pos   r_pos_x, n_pos_x;
    t_pos   r_pos_y, n_pos_y;
    logic [2:0] r_buttons, n_buttons;
    t_cfg   r_max_x, r_max_y;

    // Output register.
    logic   r_out_valid;
    t_coord r_cursor_x, r_cursor_y;
    logic   r_left, r_middle, r_right, r_click_event, r_click_kind;

    logic   s_accept;
    logic   m_accept;
    logic   pkt_done;
    t_byte  rx_byte;

    logic   neg_x, neg_y;
    t_mag   mag_x, mag_y;
    t_calc  pos_x_ext, pos_y_ext, mag_x_ext, mag_y_ext;
    t_calc  sum_x, sum_y, lim_x, lim_y;
    logic   new_left;

    assign rx_byte  = s_axis_tdata[BYTE_W-1:0];
    assign m_accept = m_axis_tvalid && m_axis_tready;
    // A byte is taken whenever the result register is empty or emptying.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign pkt_done      = s_accept && (r_phase == PH_DY);

    // Delta decode: the header carries the ninth (sign) bit of each delta.
    always_comb begin
        neg_x     = r_header[HDR_XSIGN];
        neg_y     = r_header[HDR_YSIGN];
        mag_x     = delta_mag(r_dx, neg_x);
        mag_y     = delta_mag(rx_byte, neg_y);
        pos_x_ext = t_calc'(r_pos_x);
        pos_y_ext = t_calc'(r_pos_y);
        mag_x_ext = t_calc'(mag_x);
        mag_y_ext = t_calc'(mag_y);

        // Horizontal: right moves add; left moves subtract only when the
        // position is strictly larger than the step, otherwise it holds.
        if (!neg_x) begin
            sum_x = pos_x_ext + mag_x_ext;
        end else if (pos_x_ext > mag_x_ext) begin
            sum_x = pos_x_ext - mag_x_ext;
        end else begin
            sum_x = pos_x_ext;
        end

        // Vertical is flipped: screen rows grow downward, mouse Y grows up.
        if (neg_y) begin
            sum_y = pos_y_ext + mag_y_ext;
        end else if (pos_y_ext > mag_y_ext) begin
            sum_y = pos_y_ext - mag_y_ext;
        end else begin
            sum_y = pos_y_ext;
        end

        // Clamp at the configured maximum and at the position range.
        lim_x = (t_calc'(r_max_x) < t_calc'(POS_TOP)) ? t_calc'(r_max_x) : t_calc'(POS_TOP);
        lim_y = (t_calc'(r_max_y) < t_calc'(POS_TOP)) ? t_calc'(r_max_y) : t_calc'(POS_TOP);
        if (sum_x > lim_x) begin
            sum_x = lim_x;
        end
        if (sum_y > lim_y) begin
            sum_y = lim_y;
        end
    end

    // Packet assembly and state update for the accepted byte.
    always_comb begin
        n_phase   = r_phase;
        n_header  = r_header;
        n_dx      = r_dx;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_buttons = r_buttons;
        if (s_accept) begin
            case (r_phase)
                PH_DX: begin
                    n_dx    = rx_byte;
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    n_phase   = PH_HEADER;
                    n_pos_x   = t_pos'(sum_x);
                    n_pos_y   = t_pos'(sum_y);
                    n_buttons = r_header[2:0];
                end
                default: begin
                    n_header = rx_byte;
                    n_phase  = PH_DX;
                end
            endcase
        end
    end

    assign new_left = r_header[HDR_LEFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_header      <= '0;
            r_dx          <= '0;
            r_pos_x       <= '0;
            r_pos_y       <= '0;
            r_buttons     <= '0;
            r_max_x       <= MAX_X_RESET;
            r_max_y       <= MAX_Y_RESET;
            r_out_valid   <= 1'b0;
            r_cursor_x    <= '0;
            r_cursor_y    <= '0;
            r_left        <= 1'b0;
            r_middle      <= 1'b0;
            r_right       <= 1'b0;
            r_click_event <= 1'b0;
            r_click_kind  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_header  <= n_header;
            r_dx      <= n_dx;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_buttons <= n_buttons;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_X: r_max_x <= i_cfg_data;
                    REG_MAX_Y: r_max_y <= i_cfg_data;
                    default: ;
                endcase
            end

            if (pkt_done) begin
                r_out_valid <= 1'b1;
            end else if (m_accept) begin
                r_out_valid <= 1'b0;
            end

            // Result payload; loaded only when a packet completes.
            if (pkt_done) begin
                r_cursor_x    <= t_coord'(sum_x);
                r_cursor_y    <= t_coord'(sum_y);
                r_left        <= new_left;
                r_middle      <= r_header[HDR_MIDDLE];
                r_right       <= r_header[HDR_RIGHT];
                r_click_event <= new_left != r_buttons[HDR_LEFT];
                r_click_kind  <= (new_left != r_buttons[HDR_LEFT]) && new_left;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2*COORD_W - 3){1'b0}},
                            r_right, r_middle, r_left, r_cursor_y, r_cursor_x};
    assign m_axis_tuser  = {r_click_kind, r_click_event};

    // A result shows up only right after the last byte of a packet.
    `PMT_ASSERT_RST(a_result_from_packet, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(pkt_done), "result without a completed packet")
    // Every completed packet leaves a pending result.
    `PMT_ASSERT_RST(a_packet_gives_result, i_clk, i_rst_n, pkt_done |=> m_axis_tvalid, "completed packet lost")
    // A press (click kind set) is only reported together with an event.
    `PMT_ASSERT_RST(a_kind_needs_event, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0], "click kind without click event")

endmodule

FILE: verif/tb_ps2_mouse_packet_cursor_tracker_top.sv
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_cursor_tracker_top;

    import ps2_mct_pkg::*;

    // Half clock period, reset length, settle time after a drained phase, and the overall time limit.
    localparam int    CLK_HALF_NS      = 5;
    localparam int    RESET_CYCLES     = 12;
    localparam int    SETTLE_CYCLES    = 4;
    localparam int    RUN_LIMIT_NS     = 5_000_000;
    // Random traffic: six phases of packets, three bytes each, about 1600 bytes in all.
    localparam int    NUM_PHASES       = 6;
    localparam int    PKTS_PER_PHASE   = 88;
    // Long receiver hold-off, started after a given number of drained results.
    localparam int    HOLD_OFF_CYCLES  = 200;
    localparam int    HOLD_OFF_FIRST   = 150;
    localparam int    HOLD_OFF_SECOND  = 450;

    // Position of the next byte within a three-byte packet.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } t_pkt_phase;

    // One decoded packet as reported on the master side.
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   left;
        logic   middle;
        logic   right;
        logic   click;
        logic   click_down;
    } t_cursor_report;

    // DUT ports. Every input has a known value from time zero.
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    t_cfg_idx                i_cfg_idx     = REG_MAX_X;
    t_cfg                    i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;   // [7:0] rx_byte
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [11:0] cursor_x, [23:12] cursor_y, [24] left_down, [25] middle_down,
    // [26] right_down, [31:27] zero
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // [0] click_event, [1] click_kind
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;

    // Bytes waiting to be offered, and reports the cursor tracker is expected to emit.
    t_byte          mouse_bytes[$];
    t_cursor_report cursor_reports[$];

    // Idle percentages of the two sides, changed only between phases.
    int unsigned tx_idle_pct = 32;
    int unsigned rx_idle_pct = 52;

    int unsigned mismatch_count  = 0;
    int unsigned reports_drained = 0;
    int unsigned hold_left       = 0;

    // Predictor state: our own copy of the packet assembler, cursor and clamps.
    t_pkt_phase  trk_phase   = PH_HEADER;
    t_byte       trk_header  = '0;
    t_byte       trk_xbyte   = '0;
    int          trk_x       = 0;
    int          trk_y       = 0;
    logic [2:0]  trk_buttons = '0;
    t_cfg        trk_max_x   = MAX_X_RESET;
    t_cfg        trk_max_y   = MAX_Y_RESET;

    ps2_mouse_packet_cursor_tracker_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // Prints one line per wrong field or unexpected result and counts it.
    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Feeds one accepted byte into the predictor. The third byte of a packet
    // moves the cursor and queues the report the block has to produce.
    task automatic absorb_mouse_byte(input t_byte b);
        int             dx;
        int             dy;
        int             lim;
        logic           old_left;
        t_cursor_report rep;
        case (trk_phase)
            PH_XDELTA: begin
                trk_xbyte = b;
                trk_phase = PH_YDELTA;
            end
            PH_YDELTA: begin
                trk_phase = PH_HEADER;
                // Nine-bit deltas: the header sign bit weighs -256.
                dx = int'(trk_xbyte) - (trk_header[HDR_XSIGN] ? 256 : 0);
                dy = int'(b) - (trk_header[HDR_YSIGN] ? 256 : 0);
                // X grows with a positive delta; a move left that would reach
                // zero or below is dropped altogether.
                if (dx > 0) begin
                    trk_x = trk_x + dx;
                end else if (trk_x > -dx) begin
                    trk_x = trk_x + dx;
                end
                // Y runs the other way: a positive delta moves toward zero,
                // again only if it stays above zero.
                if (dy > 0) begin
                    if (trk_y > dy) begin
                        trk_y = trk_y - dy;
                    end
                end else begin
                    trk_y = trk_y - dy;
                end
                // Saturate at the clamp registers, which never exceed the position range.
                lim = (int'(trk_max_x) < int'(POS_TOP)) ? int'(trk_max_x) : int'(POS_TOP);
                if (trk_x > lim) begin
                    trk_x = lim;
                end
                lim = (int'(trk_max_y) < int'(POS_TOP)) ? int'(trk_max_y) : int'(POS_TOP);
                if (trk_y > lim) begin
                    trk_y = lim;
                end
                old_left    = trk_buttons[HDR_LEFT];
                trk_buttons = trk_header[2:0];
                rep.x          = t_coord'(trk_x);
                rep.y          = t_coord'(trk_y);
                rep.left       = trk_buttons[HDR_LEFT];
                rep.middle     = trk_buttons[HDR_MIDDLE];
                rep.right      = trk_buttons[HDR_RIGHT];
                rep.click      = (old_left != rep.left);
                rep.click_down = rep.click & rep.left;
                cursor_reports.push_back(rep);
            end
            default: begin
                trk_header = b;
                trk_phase  = PH_XDELTA;
            end
        endcase
    endtask

    // Writes one clamp register in the block and in the predictor.
    task automatic write_limit(input t_cfg_idx idx, input t_cfg val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_MAX_X: trk_max_x = val;
            REG_MAX_Y: trk_max_y = val;
            default: ;
        endcase
    endtask

    task automatic queue_packet(input t_byte hdr, input t_byte dxb, input t_byte dyb);
        mouse_bytes.push_back(hdr);
        mouse_bytes.push_back(dxb);
        mouse_bytes.push_back(dyb);
    endtask

    // Mostly uniform delta bytes, with the magnitude extremes now and then.
    function automatic t_byte pick_delta_byte();
        t_byte b;
        b = t_byte'($urandom_range(255));
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(5))
                0: b = 8'h00;
                1: b = 8'h01;
                2: b = 8'h7F;
                3: b = 8'h80;
                4: b = 8'hFE;
                default: b = 8'hFF;
            endcase
        end
        return b;
    endfunction

    // A random packet. Four in ten lean in a chosen direction so that the cursor
    // actually travels to the clamps or to zero instead of wandering about the
    // middle; two in ten lean the other way and the rest are fully random.
    task automatic queue_random_packet(input bit lean_up);
        t_byte hdr;
        int    pick;
        bit    up;
        hdr  = t_byte'($urandom_range(255));
        pick = $urandom_range(9);
        if (pick >= 4) begin
            up = (pick < 8) ? lean_up : !lean_up;
            hdr[HDR_XSIGN] = !up;
            hdr[HDR_YSIGN] = up;
        end
        queue_packet(hdr, pick_delta_byte(), pick_delta_byte());
    endtask

    // Waits until every byte is accepted and every report has come back, then
    // lets the block settle so a register write finds it idle.
    task automatic wait_drained();
        while (mouse_bytes.size() != 0 || s_axis_tvalid || cursor_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: offers the next byte whenever the slot is free, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (mouse_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= mouse_bytes.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus two long hold-offs during which the output
    // register fills and the block has to push back on the byte stream.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                reports_drained <= reports_drained + 1;
            end
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready &&
                         (reports_drained + 1 == HOLD_OFF_FIRST ||
                          reports_drained + 1 == HOLD_OFF_SECOND)) begin
                hold_left     <= HOLD_OFF_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Monitor: predicts on every accepted byte and checks every accepted report
    // against the oldest expectation, field by field.
    always @(posedge i_clk) begin : report_check
        t_cursor_report want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_mouse_byte(t_byte'(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (cursor_reports.size() == 0) begin
                    flag_mismatch("report with none expected, cursor_x",
                                  int'(m_axis_tdata[11:0]), 0);
                end else begin
                    want = cursor_reports.pop_front();
                    if (m_axis_tdata[11:0] != want.x)
                        flag_mismatch("cursor_x", int'(m_axis_tdata[11:0]), int'(want.x));
                    if (m_axis_tdata[23:12] != want.y)
                        flag_mismatch("cursor_y", int'(m_axis_tdata[23:12]), int'(want.y));
                    if (m_axis_tdata[24] != want.left)
                        flag_mismatch("left_down", int'(m_axis_tdata[24]), int'(want.left));
                    if (m_axis_tdata[25] != want.middle)
                        flag_mismatch("middle_down", int'(m_axis_tdata[25]),
                                      int'(want.middle));
                    if (m_axis_tdata[26] != want.right)
                        flag_mismatch("right_down", int'(m_axis_tdata[26]), int'(want.right));
                    if (m_axis_tuser[0] != want.click)
                        flag_mismatch("click_event", int'(m_axis_tuser[0]), int'(want.click));
                    if (m_axis_tuser[1] != want.click_down)
                        flag_mismatch("click_kind", int'(m_axis_tuser[1]),
                                      int'(want.click_down));
                end
            end
        end
    end

    // Stimulus sequence: directed packets on the reset clamps, then random phases,
    // each with its own clamp setting and one of three idle patterns.
    initial begin
        t_cfg lim_x;
        t_cfg lim_y;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed packets, with the reset clamps of 640 by 480 in force.
        // Largest move right, nothing on Y.
        queue_packet(8'h00, 8'hFF, 8'h00);
        // Left press with both deltas at -256: X cannot go that far left, Y grows.
        queue_packet(8'h31, 8'h00, 8'h00);
        // All buttons and bit 3 set, deltas of -255 and -1.
        queue_packet(8'h3F, 8'h01, 8'hFF);
        // Overflow bits set, left release, right and middle held, +127 on both.
        queue_packet(8'hC6, 8'h7F, 8'h7F);
        // Two large moves right run X into its clamp.
        queue_packet(8'h08, 8'hFF, 8'h80);
        queue_packet(8'h09, 8'hFF, 8'h01);
        // Move left by 128; a Y delta of +255 larger than the position is dropped.
        queue_packet(8'h10, 8'h80, 8'hFF);
        // Y grows by 256, still short of its clamp.
        queue_packet(8'h20, 8'h7F, 8'h00);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Receiver idles more first, then the sender, then neither side.
            case (ph / 2)
                0: begin
                    tx_idle_pct = 32;
                    rx_idle_pct = 52;
                end
                1: begin
                    tx_idle_pct = 52;
                    rx_idle_pct = 32;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // Clamp settings: the full range, zero, random, and lopsided ones;
            // the last phase goes back to the reset values.
            case (ph)
                0: begin
                    lim_x = 12'hFFF;
                    lim_y = 12'hFFF;
                end
                1: begin
                    lim_x = 12'h000;
                    lim_y = 12'h000;
                end
                3: begin
                    lim_x = 12'h001;
                    lim_y = 12'hFFF;
                end
                4: begin
                    lim_x = 12'hFFF;
                    lim_y = 12'h001;
                end
                5: begin
                    lim_x = MAX_X_RESET;
                    lim_y = MAX_Y_RESET;
                end
                default: begin
                    lim_x = t_cfg'($urandom_range(4095));
                    lim_y = t_cfg'($urandom_range(4095));
                end
            endcase
            write_limit(REG_MAX_X, lim_x);
            write_limit(REG_MAX_Y, lim_y);
            for (int p = 0; p < PKTS_PER_PHASE; p++) begin
                queue_random_packet(ph % 2 == 0);
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard limit on the run, far beyond the slowest correct one.
    initial begin
        #RUN_LIMIT_NS;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/ps2_mct_pkg.sv
sv/ps2_mouse_packet_cursor_tracker_top.sv
verif/tb_ps2_mouse_packet_cursor_tracker_top.sv
